// File: hdl/jsu_pkg.sv
`default_nettype none
package jsu_pkg;

	// most results one item can cause: flushed surrogate (3) + 3-byte code point
	localparam int MAX_RES = 6;
	localparam int CNT_W   = 3;

	// decoder phases
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_BODY     = 3'd1;
	localparam logic [2:0] PH_ESC      = 3'd2;
	localparam logic [2:0] PH_HEX      = 3'd3;
	localparam logic [2:0] PH_HELD     = 3'd4;
	localparam logic [2:0] PH_HELD_ESC = 3'd5;

	// result status codes
	localparam logic [1:0] ST_BYTE = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	// characters of interest
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_U     = 8'h75;

	localparam logic [15:0] HI_SUR_LO = 16'hD800;
	localparam logic [15:0] HI_SUR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SUR_LO = 16'hDC00;
	localparam logic [15:0] LO_SUR_HI = 16'hDFFF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} jsu_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last_of_run;
	} jsu_out_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [15:0] code_accum;
		logic [2:0]  digit_count;
		logic [15:0] held_high;
		logic        held_valid;
	} jsu_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] status;
	} jsu_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0]           cnt;
		jsu_entry_t [MAX_RES-1:0]   ent;
	} jsu_list_t;

	typedef struct packed {
		logic [2:0]       len;
		logic [3:0][7:0]  b;
	} jsu_utf8_t;

	function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
		jsu_utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.len  = 3'd1;
			r.b[0] = {1'b0, cp[6:0]};
		end else if (cp < 21'h800) begin
			r.len  = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.len  = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.len  = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// {valid, byte} for a simple escape
	function automatic logic [8:0] esc_val(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			CH_QUOTE: r = {1'b1, CH_QUOTE};
			CH_BSL:   r = {1'b1, CH_BSL};
			CH_SLASH: r = {1'b1, CH_SLASH};
			8'h62:    r = {1'b1, 8'h08};
			8'h66:    r = {1'b1, 8'h0C};
			8'h6E:    r = {1'b1, CH_LF};
			8'h72:    r = {1'b1, CH_CR};
			8'h74:    r = {1'b1, CH_TAB};
			default:  r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hdl/jsu_decode.sv
`default_nettype none
module jsu_decode (
	input  jsu_pkg::jsu_in_t    item,
	input  jsu_pkg::jsu_state_t cur,
	output jsu_pkg::jsu_state_t nxt,
	output jsu_pkg::jsu_list_t  lst
);
	import jsu_pkg::*;

	always_comb begin
		logic [7:0]     c;
		logic [CNT_W-1:0] n;
		logic           fail;
		logic           do_body;
		logic           do_flush;
		logic [4:0]     hx;
		logic [8:0]     ev;
		logic [15:0]    acc;
		logic [2:0]     dc;
		logic           cp_valid;
		logic [20:0]    cp;
		jsu_utf8_t      uh;
		jsu_utf8_t      uc;

		c        = item.data_byte;
		nxt      = cur;
		lst      = '0;
		n        = '0;
		fail     = 1'b0;
		do_body  = 1'b0;
		do_flush = 1'b0;
		cp_valid = 1'b0;
		cp       = '0;
		hx       = hex_val(c);
		ev       = esc_val(c);
		acc      = {cur.code_accum[11:0], hx[3:0]};
		dc       = cur.digit_count + 3'd1;
		uh       = utf8_enc({5'd0, cur.held_high});

		if (item.end_of_buffer) begin
			fail = 1'b1;
		end else begin
			unique case (cur.phase)
				PH_BODY: begin
					do_body = 1'b1;
				end
				PH_ESC, PH_HELD_ESC: begin
					if (c == CH_U) begin
						nxt.code_accum  = '0;
						nxt.digit_count = '0;
						nxt.phase       = PH_HEX;
					end else if (!ev[8]) begin
						fail = 1'b1;
					end else begin
						do_flush  = (cur.phase == PH_HELD_ESC);
						nxt.phase = PH_BODY;
					end
				end
				PH_HEX: begin
					if (!hx[4]) begin
						fail = 1'b1;
					end else if (dc < 3'd4) begin
						nxt.code_accum  = acc;
						nxt.digit_count = dc;
					end else begin
						nxt.code_accum  = '0;
						nxt.digit_count = '0;
						if (cur.held_valid && acc >= LO_SUR_LO && acc <= LO_SUR_HI) begin
							// surrogate pair: 0x10000 + (hi - D800) << 10 + (lo - DC00)
							cp             = 21'h10000 + {1'b0, cur.held_high[9:0], acc[9:0]};
							cp_valid       = 1'b1;
							nxt.held_valid = 1'b0;
							nxt.held_high  = '0;
							nxt.phase      = PH_BODY;
						end else begin
							do_flush = cur.held_valid;
							if (acc >= HI_SUR_LO && acc <= HI_SUR_HI) begin
								nxt.held_high  = acc;
								nxt.held_valid = 1'b1;
								nxt.phase      = PH_HELD;
							end else begin
								nxt.held_high  = '0;
								nxt.held_valid = 1'b0;
								cp             = {5'd0, acc};
								cp_valid       = 1'b1;
								nxt.phase      = PH_BODY;
							end
						end
					end
				end
				PH_HELD: begin
					if (c == CH_BSL) begin
						nxt.phase = PH_HELD_ESC;
					end else begin
						nxt.phase = PH_BODY;
						do_flush  = 1'b1;
						do_body   = 1'b1;
					end
				end
				default: begin
					// idle and unused codes
					if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
						nxt.phase = PH_IDLE;
					end else if (c == CH_QUOTE) begin
						nxt       = '0;
						nxt.phase = PH_BODY;
					end else begin
						fail = 1'b1;
					end
				end
			endcase
		end

		// pending high surrogate goes out first as three bytes
		if (do_flush) begin
			for (int k = 0; k < 3; k++) begin
				lst.ent[n] = {uh.b[k], ST_BYTE};
				n = n + 3'd1;
			end
			nxt.held_high  = (nxt.phase == PH_HELD) ? nxt.held_high : 16'd0;
			nxt.held_valid = (nxt.phase == PH_HELD);
		end

		if ((cur.phase == PH_ESC || cur.phase == PH_HELD_ESC) && !do_body && ev[8]
				&& c != CH_U && !fail && !item.end_of_buffer) begin
			lst.ent[n] = {ev[7:0], ST_BYTE};
			n = n + 3'd1;
		end

		uc = utf8_enc(cp);
		if (cp_valid) begin
			for (int k = 0; k < 4; k++) begin
				if (3'(k) < uc.len) begin
					lst.ent[n] = {uc.b[k], ST_BYTE};
					n = n + 3'd1;
				end
			end
		end

		if (do_body) begin
			if (c == CH_QUOTE) begin
				nxt        = '0;
				lst.ent[n] = {8'd0, ST_DONE};
				n = n + 3'd1;
			end else if (c == CH_BSL) begin
				nxt.phase = PH_ESC;
			end else if (c < CH_SPACE) begin
				fail = 1'b1;
			end else begin
				nxt.phase  = PH_BODY;
				lst.ent[n] = {c, ST_BYTE};
				n = n + 3'd1;
			end
		end

		lst.cnt = n;
		if (fail) begin
			nxt        = '0;
			lst        = '0;
			lst.ent[0] = {8'd0, ST_ERR};
			lst.cnt    = 3'd1;
		end
	end

endmodule
`default_nettype wire

// File: hdl/jsu_result_buf.sv
`default_nettype none
module jsu_result_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  jsu_pkg::jsu_list_t lst,
	output logic               free,
	output logic               result_valid,
	input  logic               result_stall,
	output jsu_pkg::jsu_out_t  result_item
);
	import jsu_pkg::*;

	jsu_entry_t [MAX_RES-1:0] ent_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     pop;

	assign result_valid = (cnt_q != '0);
	assign pop          = result_valid && !result_stall;
	assign free         = !result_valid || (cnt_q == CNT_W'(1) && pop);

	assign result_item.out_byte    = ent_q[0].data;
	assign result_item.status      = ent_q[0].status;
	assign result_item.last_of_run = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= lst.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= lst.ent;
		end else if (pop) begin
			for (int k = 0; k < MAX_RES - 1; k++)
				ent_q[k] <= ent_q[k+1];
		end
	end

endmodule
`default_nettype wire

// File: hdl/json_string_unescape_utf8.sv
`default_nettype none
// Channel   Direction  Handshake                   Payload
// byte      in         byte_valid / byte_stall     byte_item   (data_byte, end_of_buffer)
// result    out        result_valid / result_stall result_item (out_byte, status, last_of_run)
//
// An accepted byte is held in the input register; the decode logic then
// updates the string state and loads zero to six result items into the result buffer.
// Items that give one result (or none) flow at one per cycle while result_stall is low; an
// item with several results keeps the result side busy until they have drained, so a
// following item with results waits in the input register, with byte_stall high meanwhile.
// Reset (arst_n low) returns to idle, awaiting an opening quote, with an empty buffer.
// result_stall holds the buffer head; a waiting item with results then raises byte_stall.
module json_string_unescape_utf8 (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  jsu_pkg::jsu_in_t  byte_item,
	output logic              result_valid,
	input  logic              result_stall,
	output jsu_pkg::jsu_out_t result_item
);
	import jsu_pkg::*;

	// input register
	logic       valid_s1;
	jsu_in_t    item_s1;

	// string decoder state
	jsu_state_t state_q;
	jsu_state_t state_nxt;
	jsu_list_t  dec_lst;

	logic buf_free;
	logic adv;
	logic accept;

	jsu_decode u_decode (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.lst  (dec_lst)
	);

	// the registered item retires once its results have somewhere to go;
	// an item with no results (whitespace, backslash, hex digit) never waits
	assign adv        = valid_s1 && (dec_lst.cnt == '0 || buf_free);
	assign byte_stall = valid_s1 && !adv;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= byte_item;
	end

	jsu_result_buf u_result_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv && dec_lst.cnt != '0),
		.lst          (dec_lst),
		.free         (buf_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule
`default_nettype wire
